// ----- src/pss_pkg.sv -----
`default_nettype none

package pss_pkg;

    // field widths of one item
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // default number of stored words
    localparam int DEFAULT_DEPTH = 16;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    // command codes
    localparam t_cmd CMD_INS_FRONT = 3'd0;
    localparam t_cmd CMD_INS_END   = 3'd1;
    localparam t_cmd CMD_INS_POS   = 3'd2;
    localparam t_cmd CMD_RM_FRONT  = 3'd3;
    localparam t_cmd CMD_RM_END    = 3'd4;
    localparam t_cmd CMD_RM_POS    = 3'd5;
    localparam t_cmd CMD_READ_ALL  = 3'd6;
    localparam t_cmd CMD_SIZE      = 3'd7;

    // status codes
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_EMPTY  = 2'd1;
    localparam t_status ST_FULL   = 2'd2;
    localparam t_status ST_BADPOS = 2'd3;

endpackage

`default_nettype wire

// ----- src/pss_ram.sv -----
`default_nettype none

module pss_ram #(
    parameter int WIDTH = pss_pkg::DATA_W,
    parameter int DEPTH = pss_pkg::DEFAULT_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/positional_sequence_store_unit.sv -----
`default_nettype none

// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+-----------------------------------------
// input    | in        | i_in_valid / o_in_stall   | i_cmd, i_position, i_value_in
// output   | out       | o_out_valid / i_out_stall | o_value_out, o_entry_count, o_status,
//          |           |                           | o_last_of_run
//
// One item at a time in a circular buffer in one RAM with a head pointer. Insert at
// front or end writes at once, size reports the count, remove fetches the word and,
// inside the sequence, closes the gap; insert inside first moves later words toward
// the end; read-all streams entries front to end through the registered RAM read.
// Synchronous reset empties the store at once, no clearing pass. A stalled
// output holds its result; the next item is taken while it waits.

module positional_sequence_store_unit #(
    parameter int DEPTH = pss_pkg::DEFAULT_DEPTH,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [pss_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [pss_pkg::POS_W-1:0]     i_position,
    input  wire logic signed [pss_pkg::DATA_W-1:0] i_value_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [pss_pkg::DATA_W-1:0]  o_value_out,
    output logic [CW-1:0]                      o_entry_count,
    output logic [pss_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_last_of_run
);

    import pss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW:0]   DEPTH_X = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHUP = 3'd1;
    localparam logic [2:0] S_SHDN = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]        r_state;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_head;
    logic [DATA_W-1:0] r_val;
    logic [CW-1:0]     r_lo;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_widx;
    logic              r_pend;
    logic              r_cap;
    logic              r_hinc;
    logic              r_rdok;
    logic [DATA_W-1:0] r_res_val;
    t_status           r_res_st;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_val;
    logic [CW-1:0]     r_out_cnt;
    t_status           r_out_st;
    logic              r_out_last;

    logic              in_acc;
    logic              out_free;
    logic              full;
    logic              empty;
    logic [LW-1:0]     pos_x;
    logic [LW-1:0]     cnt_x;
    logic [CW-1:0]     pos_l;
    logic              ins_pos_ok;
    logic              rm_pos_ok;
    logic              is_ins;
    logic              is_rm;
    logic              ins_ok;
    logic              rm_ok;
    logic [CW-1:0]     ins_at;
    logic [CW-1:0]     rm_at;
    logic [AW-1:0]     head_dec;
    logic [AW-1:0]     head_inc;
    logic [CW-1:0]     cnt_m1;
    logic              shdn_more;
    logic              read_last;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    // logical index to RAM slot, sum stays below twice the depth
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [CW-1:0] x);
        logic [CW:0] s;
        s = (CW + 1)'(head) + (CW + 1)'(x);
        if (s >= DEPTH_X) begin
            s = s - DEPTH_X;
        end
        return s[AW-1:0];
    endfunction

    pss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // handshakes
    assign in_acc     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // command decode and range checks
    assign full       = (r_count == DEPTH_C);
    assign empty      = (r_count == '0);
    assign pos_x      = LW'(i_position);
    assign cnt_x      = LW'(r_count);
    assign pos_l      = CW'(pos_x - LW'(1));
    assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + LW'(1));
    assign rm_pos_ok  = (pos_x != '0) && (pos_x <= cnt_x);
    assign cnt_m1     = r_count - CW'(1);

    assign is_ins = (i_cmd == CMD_INS_FRONT) || (i_cmd == CMD_INS_END) ||
                    (i_cmd == CMD_INS_POS);
    assign is_rm  = (i_cmd == CMD_RM_FRONT) || (i_cmd == CMD_RM_END) ||
                    (i_cmd == CMD_RM_POS);
    assign ins_ok = !full && ((i_cmd != CMD_INS_POS) || ins_pos_ok);
    assign rm_ok  = !empty && ((i_cmd != CMD_RM_POS) || rm_pos_ok);

    always_comb begin
        priority if (i_cmd == CMD_INS_FRONT) begin
            ins_at = '0;
        end else if (i_cmd == CMD_INS_END) begin
            ins_at = r_count;
        end else begin
            ins_at = pos_l;
        end
    end

    always_comb begin
        priority if (i_cmd == CMD_RM_FRONT) begin
            rm_at = '0;
        end else if (i_cmd == CMD_RM_END) begin
            rm_at = cnt_m1;
        end else begin
            rm_at = pos_l;
        end
    end

    assign head_dec  = (r_head == '0) ? LAST_SLOT : r_head - AW'(1);
    assign head_inc  = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
    assign shdn_more = r_idx < (r_hinc ? CW'(1) : r_count);
    assign read_last = (r_idx == cnt_m1);

    // RAM ports; shifts read and write distinct slots, so no forwarding
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && is_ins && ins_ok) begin
                    if (ins_at == '0) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = head_dec;
                        ram_wr_data = i_value_in;
                    end else if (ins_at == r_count) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = f_slot(r_head, r_count);
                        ram_wr_data = i_value_in;
                    end
                end
            end
            S_SHUP: begin
                ram_rd_en   = (r_idx != r_lo);
                ram_rd_addr = f_slot(r_head, r_idx - CW'(1));
                if (r_pend) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = f_slot(r_head, r_widx);
                end else if (r_idx == r_lo) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = f_slot(r_head, r_lo);
                    ram_wr_data = r_val;
                end
            end
            S_SHDN: begin
                ram_rd_en   = shdn_more;
                ram_rd_addr = f_slot(r_head, r_idx);
                ram_wr_en   = r_pend && !r_cap;
                ram_wr_addr = f_slot(r_head, r_widx);
            end
            S_READ: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = f_slot(r_head, r_idx);
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_pend  <= 1'b0;
            r_cap   <= 1'b0;
            r_hinc  <= 1'b0;
            r_rdok  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_val     <= i_value_in;
                        r_res_val <= '0;
                        r_res_st  <= ST_OK;
                        r_pend    <= 1'b0;
                        r_cap     <= 1'b0;
                        r_rdok    <= 1'b0;
                        r_state   <= S_EMIT;
                        if (is_ins) begin
                            if (full) begin
                                r_res_st <= ST_FULL;
                            end else if (!ins_ok) begin
                                r_res_st <= ST_BADPOS;
                            end else if (ins_at == '0) begin
                                r_head  <= head_dec;
                                r_count <= r_count + CW'(1);
                            end else if (ins_at == r_count) begin
                                r_count <= r_count + CW'(1);
                            end else begin
                                r_lo    <= ins_at;
                                r_idx   <= r_count;
                                r_state <= S_SHUP;
                            end
                        end else if (is_rm) begin
                            if (empty) begin
                                r_res_st <= ST_EMPTY;
                            end else if (!rm_ok) begin
                                r_res_st <= ST_BADPOS;
                            end else begin
                                r_lo    <= rm_at;
                                r_idx   <= rm_at;
                                r_hinc  <= (rm_at == '0);
                                r_state <= S_SHDN;
                            end
                        end else if (i_cmd == CMD_READ_ALL) begin
                            if (empty) begin
                                r_res_st <= ST_EMPTY;
                            end else begin
                                r_idx   <= '0;
                                r_state <= S_READ;
                            end
                        end
                    end
                end
                // move words one slot toward the end, then drop in the new word
                S_SHUP: begin
                    if (r_idx != r_lo) begin
                        r_widx <= r_idx;
                        r_idx  <= r_idx - CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_count <= r_count + CW'(1);
                            r_state <= S_EMIT;
                        end
                    end
                end
                // fetch the removed word, then close the gap
                S_SHDN: begin
                    if (r_pend && r_cap) begin
                        r_res_val <= ram_rd_data;
                    end
                    if (shdn_more) begin
                        r_widx <= r_idx - CW'(1);
                        r_cap  <= (r_idx == r_lo);
                        r_idx  <= r_idx + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_count <= cnt_m1;
                            if (r_hinc) begin
                                r_head <= head_inc;
                            end
                            r_state <= S_EMIT;
                        end
                    end
                end
                // stream entries front to end
                S_READ: begin
                    if (!r_rdok) begin
                        r_rdok <= 1'b1;
                    end else if (out_free) begin
                        r_rdok <= 1'b0;
                        if (read_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
            r_out_val   <= r_res_val;
            r_out_cnt   <= r_count;
            r_out_st    <= r_res_st;
            r_out_last  <= 1'b1;
        end else if ((r_state == S_READ) && r_rdok && out_free) begin
            r_out_valid <= 1'b1;
            r_out_val   <= ram_rd_data;
            r_out_cnt   <= r_count;
            r_out_st    <= ST_OK;
            r_out_last  <= read_last;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value_out   = r_out_val;
    assign o_entry_count = r_out_cnt;
    assign o_status      = r_out_st;
    assign o_last_of_run = r_out_last;

endmodule

`default_nettype wire
